// File: rtl/cau_pkg.sv
// shared types and codes of the complex arithmetic unit
package cau_pkg;

   typedef logic [2:0] mode_type;
   typedef logic [1:0] status_type;

   localparam mode_type MODE_ADD  = 3'd0;
   localparam mode_type MODE_SUB  = 3'd1;
   localparam mode_type MODE_MUL  = 3'd2;
   localparam mode_type MODE_DIV  = 3'd3;
   localparam mode_type MODE_CONJ = 3'd4;
   localparam mode_type MODE_NEG  = 3'd5;
   localparam mode_type MODE_MAG  = 3'd6;

   localparam status_type ST_OK  = 2'd0;
   localparam status_type ST_DZ  = 2'd1;
   localparam status_type ST_SAT = 2'd2;

endpackage

// File: rtl/cau_if.sv
// request and response channel interfaces of the complex arithmetic unit
interface cau_req_if import cau_pkg::*; #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   mode_type                     mode;
   logic signed [DATA_WIDTH-1:0] a_real;
   logic signed [DATA_WIDTH-1:0] a_imag;
   logic signed [DATA_WIDTH-1:0] b_real;
   logic signed [DATA_WIDTH-1:0] b_imag;

   modport source (output valid, mode, a_real, a_imag, b_real, b_imag, input ready);
   modport sink (input valid, mode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if import cau_pkg::*; #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] res_real;
   logic signed [DATA_WIDTH-1:0] res_imag;
   status_type                   status;

   modport source (output valid, res_real, res_imag, status, input ready);
   modport sink (input valid, res_real, res_imag, status, output ready);
endinterface

// File: rtl/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit
// Accepts one complex operation per clock and returns one result per clock, in order, as long
// as the response side is ready. Every operation, whatever its mode, passes through DATA_WIDTH+6
// register stages: two multiplier stages, a sum stage, a rounding and setup stage, DATA_WIDTH+1
// divider stages that each resolve one quotient bit (the square root shares the same slots),
// and the output register. Each stage holds its own valid bit, so empty stages close up
// behind a stalled result and new operations keep entering until the pipeline is full.
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input logic        clock,
   input logic        reset,
   cau_req_if.sink    req,
   cau_rsp_if.source  rsp
);
   localparam int W    = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int NST  = W + 6;
   localparam int LAST = NST - 1;
   localparam int DV   = W + 4;

   localparam logic signed [W:0]   MAXE = {2'b00, {(W-1){1'b1}}};
   localparam logic signed [W:0]   MINE = {2'b11, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic [2*W:0]        HALF = ((2*W+1)'(1) << F) >> 1;

   typedef struct packed {
      mode_type     mode;
      logic [W-1:0] re;
      logic [W-1:0] im;
      logic         sat;
      logic         dz;
   } side_type;

   function automatic logic [W:0] clip(input logic signed [W:0] v);
      if (v > MAXE) begin
         return {1'b1, MAXV};
      end else if (v < MINE) begin
         return {1'b1, MINV};
      end
      return {1'b0, v[W-1:0]};
   endfunction

   function automatic logic [W:0] round_mul(input logic signed [2*W:0] v);
      logic         n;
      logic [2*W:0] m, r, lim;
      n   = v[2*W];
      m   = n ? (~v + 1'b1) : v;
      r   = (m + HALF) >> F;
      lim = n ? ((2*W+1)'(1) << (W - 1)) : (((2*W+1)'(1) << (W - 1)) - 1'b1);
      if (r > lim) begin
         return {1'b1, n ? MINV : MAXV};
      end
      return {1'b0, n ? (~r[W-1:0] + 1'b1) : r[W-1:0]};
   endfunction

   function automatic logic [W:0] fin_div(input logic [W:0] qv, input logic bg,
                                          input logic n);
      logic [W+1:0] m2;
      logic [W:0]   m, lim;
      m2  = ((W+2)'(qv) + 1'b1) >> 1;
      m   = m2[W:0];
      lim = n ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - 1'b1);
      if (bg || m > lim) begin
         return {1'b1, n ? MINV : MAXV};
      end
      return {1'b0, n ? (~m[W-1:0] + 1'b1) : m[W-1:0]};
   endfunction

   logic [LAST:0] v_ff;
   logic [LAST:0] en;

   always_comb begin
      en[LAST] = ~v_ff[LAST] | rsp.ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = ~v_ff[i] | en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req.valid;
         end
         for (int i = 1; i <= LAST; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req.ready = en[0];

   // stage 0: add, subtract, conjugate, negate and operand selection
   side_type          sd_in;
   side_type          sd_ff [0:DV];
   logic signed [W:0] ea, eb, ec, ed, sre, sim;
   logic [W:0]        cre, cim;
   logic signed [W-1:0]   mx [0:5];
   logic signed [W-1:0]   my [0:5];
   logic signed [2*W-1:0] pr [0:5];
   logic                  mag_sel;

   always_comb begin
      ea = {req.a_real[W-1], req.a_real};
      eb = {req.a_imag[W-1], req.a_imag};
      ec = {req.b_real[W-1], req.b_real};
      ed = {req.b_imag[W-1], req.b_imag};
      unique case (req.mode)
         MODE_ADD: begin
            sre = ea + ec;
            sim = eb + ed;
         end
         MODE_SUB: begin
            sre = ea - ec;
            sim = eb - ed;
         end
         MODE_CONJ: begin
            sre = ea;
            sim = -eb;
         end
         MODE_NEG: begin
            sre = -ea;
            sim = -eb;
         end
         default: begin
            sre = '0;
            sim = '0;
         end
      endcase
      cre         = clip(sre);
      cim         = clip(sim);
      sd_in.mode  = req.mode;
      sd_in.re    = cre[W-1:0];
      sd_in.im    = cim[W-1:0];
      sd_in.sat   = cre[W] | cim[W];
      sd_in.dz    = 1'b0;
      mag_sel     = req.mode == MODE_MAG;
      mx[0] = req.a_real;
      my[0] = req.b_real;
      mx[1] = req.a_imag;
      my[1] = req.b_imag;
      mx[2] = req.a_real;
      my[2] = req.b_imag;
      mx[3] = req.a_imag;
      my[3] = req.b_real;
      mx[4] = mag_sel ? req.a_real : req.b_real;
      my[4] = mx[4];
      mx[5] = mag_sel ? req.a_imag : req.b_imag;
      my[5] = mx[5];
   end

   for (genvar g = 0; g < 6; g++) begin : g_mult
      cau_mult #(.W(W)) u_mult (
         .clock (clock),
         .en_lo (en[0]),
         .en_hi (en[1]),
         .x     (mx[g]),
         .y     (my[g]),
         .p     (pr[g])
      );
   end

   // stage 2: cross sums
   logic signed [2*W:0] mre_ff, mim_ff, nre_ff, nim_ff;
   logic [2*W-1:0]      sq_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         mre_ff <= {pr[0][2*W-1], pr[0]} - {pr[1][2*W-1], pr[1]};
         mim_ff <= {pr[2][2*W-1], pr[2]} + {pr[3][2*W-1], pr[3]};
         nre_ff <= {pr[0][2*W-1], pr[0]} + {pr[1][2*W-1], pr[1]};
         nim_ff <= {pr[3][2*W-1], pr[3]} - {pr[2][2*W-1], pr[2]};
         sq_ff  <= pr[4] + pr[5];
      end
   end

   // stage 3: multiply rounding, divide by zero check
   side_type   sd3_in;
   logic [W:0] rmr, rmi;

   always_comb begin
      rmr    = round_mul(mre_ff);
      rmi    = round_mul(mim_ff);
      sd3_in = sd_ff[2];
      if (sd_ff[2].mode == MODE_MUL) begin
         sd3_in.re  = rmr[W-1:0];
         sd3_in.im  = rmi[W-1:0];
         sd3_in.sat = rmr[W] | rmi[W];
      end
      sd3_in.dz = (sd_ff[2].mode == MODE_DIV) && (sq_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sd_ff[0] <= sd_in;
      end
      if (en[1]) begin
         sd_ff[1] <= sd_ff[0];
      end
      if (en[2]) begin
         sd_ff[2] <= sd_ff[1];
      end
      if (en[3]) begin
         sd_ff[3] <= sd3_in;
      end
      for (int k = 4; k <= DV; k++) begin
         if (en[k]) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   logic [W:0] qre, qim, qsq;
   logic       bre, bim, nre, nim;

   cau_div #(.W(W), .F(F)) u_div_re (
      .clock (clock),
      .en    (en[DV:3]),
      .num   (nre_ff),
      .den   (sq_ff),
      .q     (qre),
      .big   (bre),
      .neg   (nre)
   );

   cau_div #(.W(W), .F(F)) u_div_im (
      .clock (clock),
      .en    (en[DV:3]),
      .num   (nim_ff),
      .den   (sq_ff),
      .q     (qim),
      .big   (bim),
      .neg   (nim)
   );

   cau_sqrt #(.W(W)) u_sqrt (
      .clock (clock),
      .en    (en[DV:3]),
      .s     (sq_ff),
      .q     (qsq)
   );

   // output stage
   logic [W-1:0] res_real_in, res_imag_in, res_real_ff, res_imag_ff;
   status_type   status_in, status_ff;
   mode_type     mode_ff;
   logic [W:0]   dre, dim;

   always_comb begin
      dre = fin_div(qre, bre, nre);
      dim = fin_div(qim, bim, nim);
      unique case (sd_ff[DV].mode)
         MODE_DIV: begin
            if (sd_ff[DV].dz) begin
               res_real_in = '0;
               res_imag_in = '0;
               status_in   = ST_DZ;
            end else begin
               res_real_in = dre[W-1:0];
               res_imag_in = dim[W-1:0];
               status_in   = (dre[W] | dim[W]) ? ST_SAT : ST_OK;
            end
         end
         MODE_MAG: begin
            res_imag_in = '0;
            if (qsq > (W+1)'(MAXV)) begin
               res_real_in = MAXV;
               status_in   = ST_SAT;
            end else begin
               res_real_in = qsq[W-1:0];
               status_in   = ST_OK;
            end
         end
         default: begin
            res_real_in = sd_ff[DV].re;
            res_imag_in = sd_ff[DV].im;
            status_in   = sd_ff[DV].sat ? ST_SAT : ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         res_real_ff <= res_real_in;
         res_imag_ff <= res_imag_in;
         status_ff   <= status_in;
         mode_ff     <= sd_ff[DV].mode;
      end
   end

   assign rsp.valid    = v_ff[LAST];
   assign rsp.res_real = res_real_ff;
   assign rsp.res_imag = res_imag_ff;
   assign rsp.status   = status_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_DZ) |-> (rsp.res_real == '0 && rsp.res_imag == '0))
      else $error("divide by zero result not zero");

   a_mag_imag: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && mode_ff == MODE_MAG) |-> (rsp.res_imag == '0 && !rsp.res_real[W-1]))
      else $error("magnitude result malformed");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_SAT) |->
         (rsp.res_real == MAXV || rsp.res_real == MINV ||
          rsp.res_imag == MAXV || rsp.res_imag == MINV))
      else $error("saturated result not at a limit");

   a_dz_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_DZ) |-> (mode_ff == MODE_DIV))
      else $error("divide by zero status outside divide");

endmodule

// File: rtl/cau_mult.sv
// two-stage signed multiplier split into high and low partial products
module cau_mult #(parameter int W = 32) (
   input  logic                  clock,
   input  logic                  en_lo,
   input  logic                  en_hi,
   input  logic signed [W-1:0]   x,
   input  logic signed [W-1:0]   y,
   output logic signed [2*W-1:0] p
);
   localparam int H  = W / 2;
   localparam int LW = H + W + 1;
   localparam int HW = 2 * W - H;

   logic signed [LW-1:0]  lo_in, lo_ff;
   logic signed [HW-1:0]  hi_in, hi_ff;
   logic signed [2*W-1:0] p_in, p_ff;

   always_comb begin
      lo_in = $signed({{(W+1){1'b0}}, x[H-1:0]}) * $signed({{(H+1){y[W-1]}}, y});
      hi_in = $signed({{W{x[W-1]}}, x[W-1:H]}) * $signed({{(W-H){y[W-1]}}, y});
      p_in  = $signed({hi_ff, {H{1'b0}}}) + $signed({{(W-H-1){lo_ff[LW-1]}}, lo_ff});
   end

   always_ff @(posedge clock) begin
      if (en_lo) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (en_hi) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// File: rtl/cau_div.sv
// pipelined restoring divider, one quotient bit per stage
module cau_div #(parameter int W = 32, parameter int F = 16) (
   input  logic              clock,
   input  logic [W+1:0]      en,
   input  logic signed [2*W:0] num,
   input  logic [2*W-1:0]    den,
   output logic [W:0]        q,
   output logic              big,
   output logic              neg
);
   localparam int RW = 3 * W + F + 2;

   logic [RW-1:0]  r_ff   [0:W+1];
   logic [2*W-1:0] d_ff   [0:W+1];
   logic [W:0]     q_ff   [0:W+1];
   logic           big_ff [0:W+1];
   logic           neg_ff [0:W+1];

   logic [2*W:0]  mag;
   logic [RW-1:0] r0, dsh;

   always_comb begin
      mag = num[2*W] ? (~num + 1'b1) : num;
      r0  = RW'(mag) << (F + 1);
      dsh = RW'(den) << (W + 1);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0]   <= r0;
         d_ff[0]   <= den;
         q_ff[0]   <= '0;
         big_ff[0] <= r0 >= dsh;
         neg_ff[0] <= num[2*W];
      end
   end

   for (genvar k = 1; k <= W + 1; k++) begin : g_step
      localparam int B = W + 1 - k;
      logic [RW-1:0] trial, r_in;
      logic          ge;
      always_comb begin
         trial = RW'(d_ff[k-1]) << B;
         ge    = r_ff[k-1] >= trial;
         r_in  = ge ? (r_ff[k-1] - trial) : r_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (en[k]) begin
            r_ff[k]   <= r_in;
            d_ff[k]   <= d_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | ((W+1)'(ge) << B);
            big_ff[k] <= big_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   assign q   = q_ff[W+1];
   assign big = big_ff[W+1];
   assign neg = neg_ff[W+1];

endmodule

// File: rtl/cau_sqrt.sv
// pipelined digit-by-digit square root with round to nearest
module cau_sqrt #(parameter int W = 32) (
   input  logic           clock,
   input  logic [W+1:0]   en,
   input  logic [2*W-1:0] s,
   output logic [W:0]     q
);
   logic [2*W-1:0] r_ff [0:W];
   logic [W-1:0]   q_ff [0:W];
   logic [W:0]     out_ff;
   logic           rnd;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r_ff[0] <= s;
         q_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= W; k++) begin : g_step
      localparam int B = W - k;
      logic [2*W:0] trial;
      logic         ge;
      always_comb begin
         trial = ((2*W+1)'(q_ff[k-1]) << (B + 1)) + ((2*W+1)'(1) << (2 * B));
         ge    = {1'b0, r_ff[k-1]} >= trial;
      end
      always_ff @(posedge clock) begin
         if (en[k]) begin
            r_ff[k] <= ge ? (r_ff[k-1] - trial[2*W-1:0]) : r_ff[k-1];
            q_ff[k] <= q_ff[k-1] | (W'(ge) << B);
         end
      end
   end

   assign rnd = r_ff[W] > (2*W)'(q_ff[W]);

   always_ff @(posedge clock) begin
      if (en[W+1]) begin
         out_ff <= {1'b0, q_ff[W]} + (W+1)'(rnd);
      end
   end

   assign q = out_ff;

endmodule
